/* rtl/ast_pkg.sv */
// Shared types, token kinds and helpers for the assembly tokenizer.
`timescale 1ns / 1ps
package ast_pkg;
	localparam int KIND_W = 7;
	localparam logic [KIND_W-1:0] K_IDENT   = 7'd66;
	localparam logic [KIND_W-1:0] K_NUMBER  = 7'd67;
	localparam logic [KIND_W-1:0] K_STRING  = 7'd68;
	localparam logic [KIND_W-1:0] K_COMMA   = 7'd69;
	localparam logic [KIND_W-1:0] K_COLON   = 7'd70;
	localparam logic [KIND_W-1:0] K_LBRACK  = 7'd71;
	localparam logic [KIND_W-1:0] K_RBRACK  = 7'd72;
	localparam logic [KIND_W-1:0] K_PLUS    = 7'd73;
	localparam logic [KIND_W-1:0] K_MINUS   = 7'd74;
	localparam logic [KIND_W-1:0] K_STAR    = 7'd75;
	localparam logic [KIND_W-1:0] K_SLASH   = 7'd76;
	localparam logic [KIND_W-1:0] K_UNKNOWN = 7'd77;
	localparam logic [KIND_W-1:0] K_EOF     = 7'd78;

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_COMMENT = 3'd1;
	localparam logic [2:0] M_IDENT   = 3'd2;
	localparam logic [2:0] M_NUMBER  = 3'd3;
	localparam logic [2:0] M_STRING  = 3'd4;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_mark;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  kind;
		logic [15:0] line_no;
		logic [15:0] start_col;
		logic [23:0] start_offset;
		logic [15:0] text_len;
		logic        run_last;
	} out_item_t;

	// byte class decided by the front end
	localparam logic [2:0] C_SPACE   = 3'd0;
	localparam logic [2:0] C_SEMI    = 3'd1;
	localparam logic [2:0] C_QUOTE   = 3'd2;
	localparam logic [2:0] C_ALPHA   = 3'd3;
	localparam logic [2:0] C_DIGIT   = 3'd4;
	localparam logic [2:0] C_IDPUNCT = 3'd5;
	localparam logic [2:0] C_OTHER   = 3'd6;
	localparam logic [2:0] C_END     = 3'd7;

	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] cls;
		logic [6:0] pkind;
		logic       is_nl;
	} cls_item_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		to_upper = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
	endfunction

	function automatic logic [6:0] punct_kind(input logic [7:0] c);
		case (c)
			8'h2c: punct_kind = K_COMMA;
			8'h3a: punct_kind = K_COLON;
			8'h5b: punct_kind = K_LBRACK;
			8'h5d: punct_kind = K_RBRACK;
			8'h2b: punct_kind = K_PLUS;
			8'h2d: punct_kind = K_MINUS;
			8'h2a: punct_kind = K_STAR;
			8'h2f: punct_kind = K_SLASH;
			default: punct_kind = K_UNKNOWN;
		endcase
	endfunction

	// Keyword lookup on up to eight upper-cased chars, zero padded.
	function automatic logic [6:0] kw_kind(input logic [63:0] s);
		case (s)
			"MOV":    kw_kind = 7'd0;   "PUSH":   kw_kind = 7'd1;
			"POP":    kw_kind = 7'd2;   "XCHG":   kw_kind = 7'd3;
			"ADD":    kw_kind = 7'd4;   "SUB":    kw_kind = 7'd5;
			"MUL":    kw_kind = 7'd6;   "IMUL":   kw_kind = 7'd6;
			"DIV":    kw_kind = 7'd7;   "IDIV":   kw_kind = 7'd7;
			"INC":    kw_kind = 7'd8;   "DEC":    kw_kind = 7'd9;
			"NEG":    kw_kind = 7'd10;  "AND":    kw_kind = 7'd11;
			"OR":     kw_kind = 7'd12;  "XOR":    kw_kind = 7'd13;
			"NOT":    kw_kind = 7'd14;  "SHL":    kw_kind = 7'd15;
			"SHR":    kw_kind = 7'd16;  "CMP":    kw_kind = 7'd17;
			"JE":     kw_kind = 7'd18;  "JNE":    kw_kind = 7'd19;
			"JG":     kw_kind = 7'd20;  "JL":     kw_kind = 7'd21;
			"JGE":    kw_kind = 7'd22;  "JLE":    kw_kind = 7'd23;
			"JMP":    kw_kind = 7'd24;  "CALL":   kw_kind = 7'd25;
			"RET":    kw_kind = 7'd26;  "LOOP":   kw_kind = 7'd27;
			"SETE":   kw_kind = 7'd28;  "SETNE":  kw_kind = 7'd29;
			"SETG":   kw_kind = 7'd30;  "SETL":   kw_kind = 7'd31;
			"SETGE":  kw_kind = 7'd32;  "SETLE":  kw_kind = 7'd33;
			"MOVZX":  kw_kind = 7'd34;  ".DATA":  kw_kind = 7'd35;
			"DATA":   kw_kind = 7'd35;  ".CODE":  kw_kind = 7'd36;
			"CODE":   kw_kind = 7'd36;  "PROC":   kw_kind = 7'd37;
			"ENDP":   kw_kind = 7'd38;  "DB":     kw_kind = 7'd39;
			"DW":     kw_kind = 7'd40;  "DD":     kw_kind = 7'd41;
			"EQU":    kw_kind = 7'd42;  ".MODEL": kw_kind = 7'd43;
			".386":   kw_kind = 7'd44;  ".STACK": kw_kind = 7'd45;
			"EAX":    kw_kind = 7'd46;  "EBX":    kw_kind = 7'd47;
			"ECX":    kw_kind = 7'd48;  "EDX":    kw_kind = 7'd49;
			"ESI":    kw_kind = 7'd50;  "EDI":    kw_kind = 7'd51;
			"ESP":    kw_kind = 7'd52;  "EBP":    kw_kind = 7'd53;
			"AX":     kw_kind = 7'd54;  "BX":     kw_kind = 7'd55;
			"CX":     kw_kind = 7'd56;  "DX":     kw_kind = 7'd57;
			"AL":     kw_kind = 7'd58;  "BL":     kw_kind = 7'd59;
			"CL":     kw_kind = 7'd60;  "DL":     kw_kind = 7'd61;
			"AH":     kw_kind = 7'd62;  "BH":     kw_kind = 7'd63;
			"CH":     kw_kind = 7'd64;  "DH":     kw_kind = 7'd65;
			default:  kw_kind = K_IDENT;
		endcase
	endfunction
endpackage

/* rtl/ast_classify.sv */
// Front end: takes bytes, classifies them and registers the result.
`timescale 1ns / 1ps
module ast_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ast_pkg::in_item_t    in_data,
	output logic                 cls_valid,
	input  logic                 cls_ready,
	output ast_pkg::cls_item_t   cls_data
);
	import ast_pkg::*;

	logic      valid_q;
	cls_item_t data_q;
	cls_item_t next;
	logic [7:0] c;

	assign in_ready  = !valid_q || cls_ready;
	assign cls_valid = valid_q;
	assign cls_data  = data_q;
	assign c = in_data.ch;

	always_comb begin
		next.ch    = c;
		next.is_nl = (c == 8'h0a);
		next.pkind = punct_kind(c);
		if (in_data.end_mark || c == 8'h00)
			next.cls = C_END;
		else if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a)
			next.cls = C_SPACE;
		else if (c == 8'h3b)
			next.cls = C_SEMI;
		else if (c == 8'h22 || c == 8'h27)
			next.cls = C_QUOTE;
		else if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))
			next.cls = C_ALPHA;
		else if (c >= 8'h30 && c <= 8'h39)
			next.cls = C_DIGIT;
		else if (c == 8'h5f || c == 8'h2e || c == 8'h40)
			next.cls = C_IDPUNCT;
		else
			next.cls = C_OTHER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_q <= next;
	end
endmodule

/* rtl/ast_fifo.sv */
// Small result queue between the lexer core and the output port.
`timescale 1ns / 1ps
module ast_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  ast_pkg::out_item_t  wr_data,
	output logic [2:0]          free_cnt,
	output logic                rd_valid,
	input  logic                rd_ready,
	output ast_pkg::out_item_t  rd_data
);
	import ast_pkg::*;

	out_item_t  mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data  = mem_q[rp_q];
	assign pop      = rd_valid && rd_ready;
	assign free_cnt = 3'd4 - cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr_en} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
endmodule

/* rtl/ast_lexer.sv */
// Back end: lexer state machine; emits up to two tokens per byte.
`timescale 1ns / 1ps
module ast_lexer #(
	parameter int KEY_CHARS   = 6,
	parameter int LINE_BITS   = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cls_valid,
	output logic                cls_ready,
	input  ast_pkg::cls_item_t  cls_data,
	input  logic [2:0]          free_cnt,
	output logic                wr_en,
	output ast_pkg::out_item_t  wr_data
);
	import ast_pkg::*;

	localparam logic [LINE_BITS-1:0]   LMAX = '1;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;

	logic [2:0]             mode_q;
	logic                   dq_q;
	logic [LINE_BITS-1:0]   line_q, col_q, tcol_q;
	logic [OFFSET_BITS-1:0] pos_q, toff_q;
	logic [15:0]            tlen_q;
	logic [7:0]             up_q [KEY_CHARS];
	logic                   stop_q;

	// second write slot, drained the cycle after
	logic      pend_q;
	out_item_t pend_data_q;

	logic       go;
	logic       flush, emit2;
	out_item_t  t1, t2;
	logic [2:0] mode_d;
	logic       adv, cont, start_tok, start_str;
	logic [LINE_BITS-1:0] line_a, col_a;
	logic [OFFSET_BITS-1:0] pos_a;
	logic [63:0] kstr;
	logic [5:0]  ksh;
	logic [6:0]  fkind;
	logic [7:0]  c;
	logic [2:0]  cl;

	assign c  = cls_data.ch;
	assign cl = cls_data.cls;
	// a byte is taken only with room for three results, so it is never held half done
	assign cls_ready = !pend_q && (free_cnt >= 3'd3);
	assign go = cls_valid && cls_ready && !stop_q;

	always_comb begin
		kstr = '0;
		for (int i = 0; i < KEY_CHARS; i++)
			if (i < 8) kstr[63-8*i -: 8] = up_q[i];
		// chars sit left aligned; shift them down to line up with the table literals
		ksh = {3'(4'd8 - tlen_q[3:0]), 3'b000};
		fkind = K_NUMBER;
		case (mode_q)
			M_IDENT:  fkind = (tlen_q > 16'(KEY_CHARS)) ? K_IDENT : kw_kind(kstr >> ksh);
			M_STRING: fkind = K_STRING;
			default:  fkind = K_NUMBER;
		endcase
	end

	always_comb begin
		line_a = (cls_data.is_nl && line_q != LMAX) ? line_q + 1'b1 : line_q;
		col_a  = cls_data.is_nl ? LINE_BITS'(1) : ((col_q != LMAX) ? col_q + 1'b1 : col_q);
		pos_a  = (pos_q != OMAX) ? pos_q + 1'b1 : pos_q;
	end

	always_comb begin
		flush = 1'b0; emit2 = 1'b0; adv = 1'b0; cont = 1'b0;
		start_tok = 1'b0; start_str = 1'b0;
		mode_d = mode_q;
		t1 = '0; t2 = '0;
		t1.kind = fkind;
		t1.start_col = 16'(tcol_q);
		t1.start_offset = 24'(toff_q);
		t1.text_len = tlen_q;
		t1.line_no = 16'(line_q);
		t2.line_no = 16'(line_q);
		t2.start_col = 16'(col_q);
		t2.start_offset = 24'(pos_q);
		t2.text_len = 16'd1;
		t2.kind = cls_data.pkind;
		if (cl == C_END) begin
			flush = (mode_q != M_IDLE) && (mode_q != M_COMMENT);
			emit2 = 1'b1;
			t2.kind = K_EOF;
			t2.text_len = '0;
			mode_d = M_IDLE;
		end else begin
			case (mode_q)
				M_IDENT: cont = (cl == C_ALPHA) || (cl == C_DIGIT) || (cl == C_IDPUNCT)
					|| (c == 8'h3f);
				M_NUMBER: cont = (cl == C_ALPHA) || (cl == C_DIGIT);
				M_STRING: begin
					cont = 1'b1;
					adv  = 1'b1;
					if (c == (dq_q ? 8'h22 : 8'h27)) begin
						flush = 1'b1;
						t1.line_no = 16'(line_a);
						mode_d = M_IDLE;
					end
				end
				M_COMMENT: begin
					cont = 1'b1;
					adv  = 1'b1;
					if (cls_data.is_nl) mode_d = M_IDLE;
				end
				default: cont = 1'b0;
			endcase
			if ((mode_q == M_IDENT || mode_q == M_NUMBER) && cont) adv = 1'b1;
			if (!cont) begin
				flush = (mode_q != M_IDLE);
				adv = 1'b1;
				mode_d = M_IDLE;
				case (cl)
					C_SPACE: ;
					C_SEMI:  mode_d = M_COMMENT;
					C_QUOTE: begin start_str = 1'b1; mode_d = M_STRING; end
					C_ALPHA, C_IDPUNCT: begin start_tok = 1'b1; mode_d = M_IDENT; end
					C_DIGIT: begin start_tok = 1'b1; mode_d = M_NUMBER; end
					default: begin
						emit2 = 1'b1;
						t2.line_no = 16'(line_a);
					end
				endcase
			end
		end
		t1.run_last = !emit2;
		t2.run_last = 1'b1;
	end

	assign wr_en   = (go && (flush || emit2)) || pend_q;
	always_comb begin
		if (pend_q) wr_data = pend_data_q;
		else if (flush) wr_data = t1;
		else wr_data = t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			dq_q   <= 1'b0;
			line_q <= LINE_BITS'(1);
			col_q  <= LINE_BITS'(1);
			pos_q  <= '0;
			tcol_q <= '0;
			toff_q <= '0;
			tlen_q <= '0;
			for (int i = 0; i < KEY_CHARS; i++) up_q[i] <= '0;
			stop_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= go && flush && emit2;
			if (go) begin
				mode_q <= mode_d;
				if (cl == C_END) stop_q <= 1'b1;
				if (adv) begin
					line_q <= line_a;
					col_q  <= col_a;
					pos_q  <= pos_a;
				end
				if (cont && mode_q == M_IDENT) begin
					for (int i = 0; i < KEY_CHARS; i++)
						if (tlen_q == 16'(i)) up_q[i] <= to_upper(c);
				end
				if (cont && (mode_q == M_IDENT || mode_q == M_NUMBER ||
						(mode_q == M_STRING && !flush)) && tlen_q != 16'hffff)
					tlen_q <= tlen_q + 16'd1;
				if (start_str) begin
					dq_q   <= (c == 8'h22);
					tcol_q <= col_q;
					toff_q <= pos_a;
					tlen_q <= '0;
				end
				if (start_tok) begin
					tcol_q <= col_q;
					toff_q <= pos_q;
					tlen_q <= 16'd1;
					if (cl != C_DIGIT) begin
						for (int i = 1; i < KEY_CHARS; i++) up_q[i] <= '0;
						up_q[0] <= to_upper(c);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && flush && emit2) pend_data_q <= t2;
	end
endmodule

/* rtl/assembly_source_tokenizer.sv */
// Top level of the assembly source tokenizer.
`timescale 1ns / 1ps
// Streaming tokenizer: one source byte is taken per cycle while the result
// queue has room. A byte that both closes a token and forms a punctuation or
// eof token yields two items; the second goes out the following cycle,
// in which no byte is taken. A registered classify stage feeds the
// lexer core, and a four-entry result queue decouples it from the output port.
// After eof no further items are produced and later bytes are dropped.
module assembly_source_tokenizer #(
	parameter int KEY_CHARS   = 6,
	parameter int LINE_BITS   = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ast_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ast_pkg::out_item_t  out_data
);
	import ast_pkg::*;

	logic      cls_valid, cls_ready;
	cls_item_t cls_data;
	logic      wr_en;
	out_item_t wr_data;
	logic [2:0] free_cnt;

	ast_classify u_cls (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.cls_valid, .cls_ready, .cls_data
	);

	ast_lexer #(
		.KEY_CHARS(KEY_CHARS), .LINE_BITS(LINE_BITS), .OFFSET_BITS(OFFSET_BITS)
	) u_lex (
		.clk, .arst_n, .cls_valid, .cls_ready, .cls_data,
		.free_cnt, .wr_en, .wr_data
	);

	ast_fifo u_fifo (
		.clk, .arst_n, .wr_en, .wr_data, .free_cnt,
		.rd_valid(out_valid), .rd_ready(out_ready), .rd_data(out_data)
	);
endmodule
